// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define MPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expr must never be true outside reset
`define MPD_NEVER(lbl, expr, msg) \
  `MPD_ASSERT(lbl, !(expr), msg)

`endif

// ----- rtl/mpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the MQTT PUBLISH deframer.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int CNT_W   = 28;   // remaining length width
  localparam int TLEN_W  = 16;   // topic length width

  localparam logic [27:0] OVERSIZE_RESET   = 28'd65536;
  localparam logic [15:0] TOPIC_KEEP_RESET = 16'd255;
  localparam logic [3:0]  TYPE_PUBLISH     = 4'h3;

  // configuration register indexes
  localparam logic REG_OVERSIZE   = 1'b0;
  localparam logic REG_TOPIC_KEEP = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_DRAIN   = 3'd2,
    PH_TLEN_HI = 3'd3,
    PH_TLEN_LO = 3'd4,
    PH_TOPIC   = 3'd5,
    PH_PID     = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_TOPIC = 2'd1,
    KIND_PAY   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CNT_W-1:0]  oversize_limit;
    logic [TLEN_W-1:0] topic_keep_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       msg_end;
  } res_t;

endpackage

// ----- rtl/mpd_cfg.sv -----
// ----------------------------------------------------------------------------
// mpd_cfg
// Configuration register file: oversize limit and topic keep limit.
// ----------------------------------------------------------------------------
module mpd_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [27:0]         cfg_data,
  output mpd_pkg::cfg_t       cfg
);
  import mpd_pkg::*;

  logic [CNT_W-1:0]  oversize_limit;
  logic [TLEN_W-1:0] topic_keep_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversize_limit   <= OVERSIZE_RESET;
      topic_keep_limit <= TOPIC_KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OVERSIZE:   oversize_limit   <= cfg_data;
        REG_TOPIC_KEEP: topic_keep_limit <= cfg_data[TLEN_W-1:0];
      endcase
    end
  end

  assign cfg.oversize_limit   = oversize_limit;
  assign cfg.topic_keep_limit = topic_keep_limit;

endmodule

// ----- rtl/mpd_parse.sv -----
// ----------------------------------------------------------------------------
// mpd_parse
// Per-byte parse state machine; produces one tagged result per byte.
// ----------------------------------------------------------------------------
module mpd_parse #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  input  mpd_pkg::cfg_t  cfg,
  output mpd_pkg::res_t  res
);
  import mpd_pkg::*;
  `include "assert_macros.svh"

  phase_t            phase, phase_next;
  logic [7:0]        header_byte, header_byte_next;
  logic [1:0]        length_idx, length_idx_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic [TLEN_W-1:0] topic_length, topic_length_next;
  logic [TLEN_W-1:0] topic_pos, topic_pos_next;
  logic              deliver, deliver_next;

  logic              consumed;
  logic [CNT_W-1:0]  cnt_dec;
  logic              pkt_done;
  logic [CNT_W-1:0]  len_add;
  logic [CNT_W-1:0]  len_sum;
  logic              len_last_slot;
  logic              qos_nz;
  logic [TLEN_W-1:0] tlen_full;
  logic [TLEN_W:0]   tlen_need;
  logic [CNT_W-1:0]  rest;
  logic              topic_fits;
  logic [TLEN_W-1:0] topic_pos_inc;
  phase_t            phase_after_topic;

  assign consumed = (phase != PH_HEADER) && (phase != PH_LENGTH);
  assign cnt_dec  = (remaining != '0) ? remaining - CNT_W'(1) : '0;
  assign pkt_done = consumed && (cnt_dec == '0);
  assign qos_nz   = header_byte[2:1] != 2'b00;

  // 7-bit length groups, least significant first
  always_comb begin
    case (length_idx)
      2'd0:    len_add = {21'd0, rx_byte[6:0]};
      2'd1:    len_add = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_add = {7'd0, rx_byte[6:0], 14'd0};
      default: len_add = {rx_byte[6:0], 21'd0};
    endcase
  end
  assign len_sum       = remaining + len_add;
  assign len_last_slot = ({1'b0, length_idx} + 3'd1) >= 3'(MAX_LENGTH_BYTES);

  assign tlen_full  = {topic_length[15:8], rx_byte};
  assign tlen_need  = {1'b0, tlen_full} + (qos_nz ? 17'd2 : 17'd0);
  assign rest       = remaining - CNT_W'(1);
  assign topic_fits = !({11'd0, tlen_need} > rest);

  assign topic_pos_inc     = topic_pos + TLEN_W'(1);
  assign phase_after_topic = qos_nz ? PH_PID : PH_PAYLOAD;

  // next state
  always_comb begin
    phase_next        = phase;
    header_byte_next  = header_byte;
    length_idx_next   = length_idx;
    remaining_next    = remaining;
    topic_length_next = topic_length;
    topic_pos_next    = topic_pos;
    deliver_next      = deliver;
    unique case (phase)
      PH_HEADER: begin
        header_byte_next = rx_byte;
        length_idx_next  = '0;
        remaining_next   = '0;
        deliver_next     = 1'b0;
        phase_next       = PH_LENGTH;
      end
      PH_LENGTH: begin
        remaining_next = len_sum;
        if (rx_byte[7]) begin
          if (len_last_slot) begin
            remaining_next  = '0;
            length_idx_next = '0;
            phase_next      = PH_HEADER;
          end else begin
            length_idx_next = length_idx + 2'd1;
          end
        end else begin
          length_idx_next = '0;
          if (len_sum == '0)                          phase_next = PH_HEADER;
          else if (len_sum > cfg.oversize_limit)      phase_next = PH_DRAIN;
          else if (header_byte[7:4] != TYPE_PUBLISH)  phase_next = PH_DRAIN;
          else if (len_sum < CNT_W'(2))               phase_next = PH_DRAIN;
          else                                        phase_next = PH_TLEN_HI;
        end
      end
      PH_DRAIN: ;
      PH_TLEN_HI: begin
        topic_length_next = {rx_byte, 8'd0};
        phase_next        = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        topic_length_next = tlen_full;
        topic_pos_next    = '0;
        if (!topic_fits) begin
          deliver_next = 1'b0;
          phase_next   = PH_DRAIN;
        end else begin
          deliver_next = 1'b1;
          if (tlen_full != '0) begin
            phase_next = PH_TOPIC;
          end else begin
            length_idx_next = '0;
            phase_next      = phase_after_topic;
          end
        end
      end
      PH_TOPIC: begin
        topic_pos_next = topic_pos_inc;
        if (topic_pos_inc >= topic_length) begin
          length_idx_next = '0;
          phase_next      = phase_after_topic;
        end
      end
      PH_PID: begin
        if (length_idx == 2'd1) begin
          length_idx_next = '0;
          phase_next      = PH_PAYLOAD;
        end else begin
          length_idx_next = length_idx + 2'd1;
        end
      end
      PH_PAYLOAD: ;
    endcase
    if (consumed) begin
      remaining_next = cnt_dec;
    end
    if (pkt_done) begin
      deliver_next    = 1'b0;
      length_idx_next = '0;
      phase_next      = PH_HEADER;
    end
  end

  // result
  always_comb begin
    res.data    = rx_byte;
    res.kind    = KIND_FRAME;
    res.msg_end = 1'b0;
    unique case (phase)
      PH_LENGTH:  if (rx_byte[7] && len_last_slot) res.kind = KIND_ERR;
      PH_TOPIC:   if (topic_pos < cfg.topic_keep_limit) res.kind = KIND_TOPIC;
      PH_PAYLOAD: res.kind = KIND_PAY;
      default:    res.kind = KIND_FRAME;
    endcase
    if (pkt_done) begin
      res.msg_end = (phase == PH_TLEN_LO) ? topic_fits : deliver;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_byte  <= '0;
      length_idx   <= '0;
      remaining    <= '0;
      topic_length <= '0;
      topic_pos    <= '0;
      deliver      <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      header_byte  <= header_byte_next;
      length_idx   <= length_idx_next;
      remaining    <= remaining_next;
      topic_length <= topic_length_next;
      topic_pos    <= topic_pos_next;
      deliver      <= deliver_next;
    end
  end

  `MPD_ASSERT(a_len_idx_range, (phase != PH_LENGTH || ({1'b0, length_idx} < 3'(MAX_LENGTH_BYTES))), "length index past limit")
  `MPD_ASSERT(a_header_clean, (phase != PH_HEADER || (length_idx == '0 && !deliver)), "header phase with stale state")
  `MPD_ASSERT(a_pid_delivers, (phase != PH_PID || deliver), "packet id phase without delivery")
  `MPD_ASSERT(a_body_count, (!consumed || remaining != '0), "body byte with zero count")

endmodule

// ----- rtl/mpd_outbuf.sv -----
// ----------------------------------------------------------------------------
// mpd_outbuf
// Result register plus skid entry; decouples input stall from output stall.
// ----------------------------------------------------------------------------
module mpd_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpd_pkg::res_t  push_res,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output mpd_pkg::res_t  out_res
);
  import mpd_pkg::*;
  `include "assert_macros.svh"

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;
  logic pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !main_valid) begin
      main_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

  `MPD_ASSERT(a_skid_needs_main, (!skid_valid || main_valid), "skid entry without main entry")
  `MPD_ASSERT(a_skid_drains, ((skid_valid && !out_stall) |=> (main_valid && !skid_valid)), "skid entry not moved up")
  `MPD_NEVER(a_no_push_full, (push && skid_valid), "push into full buffer")

endmodule

// ----- rtl/mqtt_publish_deframer_top.sv -----
// ----------------------------------------------------------------------------
// Each accepted byte is registered in the result register or the skid entry.
// Throughput: one byte per cycle unless in_stall; one parse update per byte.
// in_stall rises only when both output entries are full (out_stall held).
// Reset (rst, synchronous): parse restarts at a fixed header byte, output
// buffer empties, oversize_limit = 65536 and topic_keep_limit = 255.
// ----------------------------------------------------------------------------
// mqtt_publish_deframer_top
// Streams a received MQTT byte stream; tags PUBLISH topic and payload bytes.
// ----------------------------------------------------------------------------
module mqtt_publish_deframer_top #(
  parameter int MAX_LENGTH_BYTES = 4   // remaining length bytes, 1 to 4
) (
  input  logic        clk,
  input  logic        rst,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_kind,
  output logic        message_end,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [27:0] cfg_data
);
  import mpd_pkg::*;

  cfg_t cfg;
  res_t step_res;
  res_t out_res;
  logic buf_full;
  logic step;

  // A byte is taken whenever the skid entry is free; the parse state
  // advances on exactly those edges.
  assign in_stall = buf_full;
  assign step     = in_valid && !in_stall;

  mpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // header / length / topic / packet id / payload sequencing
  mpd_parse #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  // result register with one skid entry behind it
  mpd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_res  (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte    = out_res.data;
  assign byte_kind   = out_res.kind;
  assign message_end = out_res.msg_end;

endmodule
